// ----- design/lzwh_pkg.sv -----
// Shared types and constants of the hashed-table LZW compressor.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package lzwh_pkg;

    localparam int unsigned TAB_DEPTH = 4096;
    localparam int unsigned TAB_AW    = 12;

    localparam logic [TAB_AW-1:0] TAB_LAST      = 12'hFFF;
    localparam logic [TAB_AW-1:0] STEP_LAST     = 12'hFFF;
    localparam logic [TAB_AW-1:0] NOT_FOUND     = 12'hFFF;
    localparam logic [TAB_AW-1:0] PROBE_STEP    = 12'd101;
    localparam logic [TAB_AW-1:0] GROWTH_LIMIT  = 12'd3840;
    localparam logic [12:0]       NO_PREFIX     = 13'h1000;
    localparam logic [15:0]       ROOT_HASH_BASE = 16'hFFFF;
    localparam logic [16:0]       HASH_OR       = 17'h00800;
    localparam logic [7:0]        LAST_ROOT     = 8'hFF;

    // One input word after the front has taken it.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_block;
        logic       last_of_block;
    } t_cmd;

    // One packed output byte with its end-of-item mark.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } t_obyte;

endpackage

// ----- design/lzw_hashed_compressor.sv -----
// Top level of the 12-bit hashed-table LZW compressor.
// Depends on lzwh_pkg, lzwh_front, lzwh_engine and lzwh_out.
`timescale 1ns / 1ps

//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata = data_byte, tuser = first_of_block,
//                                            tlast = last_of_block
//  m_axis    out  tvalid/tready              tdata = out_byte, tlast = last_out
//
// A byte that extends the current string runs the hash states and one walk step per chain
// link; a miss adds the code packing, an insert (hash, walk, probe) while growth is left,
// and a root lookup. Memory read latency of the table sets each step.
// After reset the table is cleared (all 4096 entries) and loaded with 256 roots before any
// word is taken; a first_of_block word repeats that rebuild inside the engine.
// A two-word command queue and a four-byte output queue decouple both streams.

module lzw_hashed_compressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] first_of_block
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);
    import lzwh_pkg::*;

    logic   w_cmd_valid, w_cmd_pop, w_init_busy, w_push, w_full;
    t_cmd   w_cmd;
    t_obyte w_byte;

    lzwh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_hold          (w_init_busy),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    lzwh_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_init_busy (w_init_busy),
        .o_push      (w_push),
        .o_byte      (w_byte),
        .i_out_full  (w_full)
    );

    lzwh_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .i_byte          (w_byte),
        .o_full          (w_full),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- design/lzwh_front.sv -----
// Input side: accepts words from the slave stream into a two-entry command queue.
// Depends on lzwh_pkg (t_cmd).
`timescale 1ns / 1ps

module lzwh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,
    input  logic [0:0]     i_s_axis_tuser,
    input  logic           i_s_axis_tlast,
    input  logic           i_hold,
    output logic           o_cmd_valid,
    output lzwh_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);
    import lzwh_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_s_axis_tready = (r_cnt != 2'd2) && !i_hold;
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_cnt != 2'd0);
    assign o_cmd           = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{data_byte:      i_s_axis_tdata,
                           first_of_block: i_s_axis_tuser[0],
                           last_of_block:  i_s_axis_tlast};
        end
    end

endmodule

// ----- design/lzwh_out.sv -----
// Output side: four-entry byte queue that drives the master stream.
// Depends on lzwh_pkg (t_obyte).
`timescale 1ns / 1ps

module lzwh_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lzwh_pkg::t_obyte i_byte,
    output logic             o_full,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,
    output logic             o_m_axis_tlast
);
    import lzwh_pkg::*;

    t_obyte     r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_full          = (r_cnt == 3'd4);
    assign o_m_axis_tvalid = (r_cnt != 3'd0);
    assign o_m_axis_tdata  = r_q[r_rp].out_byte;
    assign o_m_axis_tlast  = r_q[r_rp].last_out;
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_byte;
    end

endmodule

// ----- design/lzwh_engine.sv -----
// Back end: string table memory, hash, chain walk, probe and code packing.
// Depends on lzwh_pkg (t_cmd, t_obyte, table constants).
`timescale 1ns / 1ps

module lzwh_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  lzwh_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    output logic             o_init_busy,
    output logic             o_push,
    output lzwh_pkg::t_obyte o_byte,
    input  logic             i_out_full
);
    import lzwh_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_CLR    = 17'b00000000000000010,
        S_RSTART = 17'b00000000000000100,
        S_H1     = 17'b00000000000001000,
        S_H2     = 17'b00000000000010000,
        S_H3     = 17'b00000000000100000,
        S_FWALK  = 17'b00000000001000000,
        S_LAST   = 17'b00000000010000000,
        S_PUT    = 17'b00000000100000000,
        S_FLUSH  = 17'b00000001000000000,
        S_AHEAD  = 17'b00000010000000000,
        S_AWALK  = 17'b00000100000000000,
        S_PSTART = 17'b00001000000000000,
        S_PROBE  = 17'b00010000000000000,
        S_AWRITE = 17'b00100000000000000,
        S_ADONE  = 17'b01000000000000000
    } t_state;

    typedef enum logic [1:0] {
        OP_RINS  = 2'd0,
        OP_MATCH = 2'd1,
        OP_ADD   = 2'd2,
        OP_RFIND = 2'd3
    } t_op;

    // table memory, one array per field; all fields share one write address and one read address
    logic              mem_used [TAB_DEPTH];
    logic [TAB_AW-1:0] mem_link [TAB_DEPTH];
    logic [12:0]       mem_pfx  [TAB_DEPTH];
    logic [7:0]        mem_sfx  [TAB_DEPTH];

    logic              r_rd_used;
    logic [TAB_AW-1:0] r_rd_link;
    logic [12:0]       r_rd_pfx;
    logic [7:0]        r_rd_sfx;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic              r_init, n_init;
    logic [TAB_AW-1:0] r_clr, n_clr;
    logic [7:0]        r_root, n_root;
    logic [7:0]        r_sym, n_sym;
    logic              r_last, n_last;
    logic [TAB_AW-1:0] r_cur, n_cur;
    logic [3:0]        r_held, n_held;
    logic              r_pend, n_pend;
    logic              r_half, n_half;
    logic [TAB_AW-1:0] r_left, n_left;
    logic [12:0]       r_hpfx, n_hpfx;
    logic [7:0]        r_hsym, n_hsym;
    logic [16:0]       r_hv, n_hv;
    logic [TAB_AW-1:0] r_idx, n_idx;
    logic [TAB_AW-1:0] r_t, n_t;
    logic [TAB_AW-1:0] r_step, n_step;
    logic [TAB_AW-1:0] r_ecode, n_ecode;
    logic              r_emiss, n_emiss;

    logic              w_we_ent, w_we_link;
    logic [TAB_AW-1:0] w_waddr, w_raddr;
    logic              w_wused;
    logic [TAB_AW-1:0] w_wlink;
    logic [12:0]       w_wpfx;
    logic [7:0]        w_wsfx;
    logic [16:0]       w_hbase;
    logic [33:0]       w_sq;
    logic              w_match;
    logic              w_done;

    assign w_hbase = (r_hpfx == NO_PREFIX) ? {1'b0, ROOT_HASH_BASE} : {4'b0, r_hpfx};
    assign w_sq    = {17'b0, r_hv} * {17'b0, r_hv};
    assign w_match = (r_rd_pfx == r_hpfx) && (r_rd_sfx == r_hsym);
    assign o_init_busy = r_init;

    always_comb begin
        n_state = r_state;  n_op = r_op;     n_init = r_init;  n_clr = r_clr;
        n_root  = r_root;   n_sym = r_sym;   n_last = r_last;  n_cur = r_cur;
        n_held  = r_held;   n_pend = r_pend; n_half = r_half;  n_left = r_left;
        n_hpfx  = r_hpfx;   n_hsym = r_hsym; n_hv = r_hv;      n_idx = r_idx;
        n_t     = r_t;      n_step = r_step; n_ecode = r_ecode; n_emiss = r_emiss;
        w_raddr   = r_idx;
        w_waddr   = r_idx;
        w_we_ent  = 1'b0;
        w_we_link = 1'b0;
        w_wused   = 1'b0;
        w_wlink   = '0;
        w_wpfx    = '0;
        w_wsfx    = '0;
        w_done    = 1'b0;
        o_cmd_pop = 1'b0;
        o_push    = 1'b0;
        o_byte    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_sym     = i_cmd.data_byte;
                    n_last    = i_cmd.last_of_block;
                    if (i_cmd.first_of_block) begin
                        n_held  = 4'd0;
                        n_pend  = 1'b0;
                        n_clr   = '0;
                        n_state = S_CLR;
                    end else begin
                        n_op    = OP_MATCH;
                        n_hpfx  = {1'b0, r_cur};
                        n_hsym  = i_cmd.data_byte;
                        n_state = S_H1;
                    end
                end
            end
            S_CLR: begin
                w_we_ent  = 1'b1;
                w_we_link = 1'b1;
                w_waddr   = r_clr;
                n_clr     = r_clr + 12'd1;
                if (r_clr == TAB_LAST) begin
                    n_root  = 8'd0;
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                n_op    = OP_RINS;
                n_hpfx  = NO_PREFIX;
                n_hsym  = r_root;
                n_state = S_H1;
            end
            S_H1: begin
                n_hv    = (w_hbase + {9'b0, r_hsym}) | HASH_OR;
                n_state = S_H2;
            end
            S_H2: begin
                n_idx   = w_sq[17:6];
                n_state = S_H3;
            end
            S_H3: begin
                w_raddr = r_idx;
                n_step  = '0;
                n_state = (r_op == OP_RINS || r_op == OP_ADD) ? S_AHEAD : S_FWALK;
            end
            S_FWALK: begin
                if (w_match) begin
                    n_cur   = r_idx;
                    n_state = S_LAST;
                end else if (r_rd_link == '0 || r_step == STEP_LAST) begin
                    if (r_op == OP_MATCH) begin
                        n_ecode = r_cur;
                        n_emiss = 1'b1;
                        n_half  = 1'b0;
                        n_state = S_PUT;
                    end else begin
                        n_cur   = NOT_FOUND;
                        n_state = S_LAST;
                    end
                end else begin
                    n_idx   = r_rd_link;
                    w_raddr = r_rd_link;
                    n_step  = r_step + 12'd1;
                end
            end
            S_LAST: begin
                if (r_last) begin
                    n_ecode = r_cur;
                    n_emiss = 1'b0;
                    n_half  = 1'b0;
                    n_state = S_PUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PUT: begin
                if (!i_out_full) begin
                    o_push = 1'b1;
                    if (!r_pend) begin
                        o_byte = '{out_byte: r_ecode[11:4], last_out: r_emiss && !r_last};
                        n_held = r_ecode[3:0];
                        n_pend = 1'b1;
                        w_done = 1'b1;
                    end else if (!r_half) begin
                        o_byte = '{out_byte: {r_held, r_ecode[11:8]}, last_out: 1'b0};
                        n_half = 1'b1;
                    end else begin
                        o_byte = '{out_byte: r_ecode[7:0], last_out: !r_emiss || !r_last};
                        n_pend = 1'b0;
                        n_half = 1'b0;
                        w_done = 1'b1;
                    end
                    if (w_done) begin
                        if (r_emiss) begin
                            n_hsym  = r_sym;
                            n_state = S_H1;
                            if (r_left != '0) begin
                                n_left = r_left - 12'd1;
                                n_op   = OP_ADD;
                                n_hpfx = {1'b0, r_ecode};
                            end else begin
                                n_op   = OP_RFIND;
                                n_hpfx = NO_PREFIX;
                            end
                        end else begin
                            // a code that leaves a nibble behind needs the flush byte
                            n_state = r_pend ? S_IDLE : S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!i_out_full) begin
                    o_push  = 1'b1;
                    o_byte  = '{out_byte: {r_held, 4'h0}, last_out: 1'b1};
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_AHEAD: begin
                if (!r_rd_used) begin
                    w_we_ent  = 1'b1;
                    w_we_link = 1'b1;
                    w_waddr   = r_idx;
                    w_wused   = 1'b1;
                    w_wpfx    = r_hpfx;
                    w_wsfx    = r_hsym;
                    n_state   = S_ADONE;
                end else begin
                    w_raddr = r_idx;
                    n_state = S_AWALK;
                end
            end
            S_AWALK: begin
                // follow the chain to its end, at most one pass over the table
                if (r_rd_link != '0) begin
                    n_idx   = r_rd_link;
                    w_raddr = r_rd_link;
                    n_step  = r_step + 12'd1;
                    if (r_step == STEP_LAST) n_state = S_PSTART;
                end else begin
                    n_state = S_PSTART;
                end
            end
            S_PSTART: begin
                w_raddr = r_idx + PROBE_STEP;
                n_t     = r_idx + PROBE_STEP;
                n_step  = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (!r_rd_used) begin
                    w_we_link = 1'b1;
                    w_waddr   = r_idx;
                    w_wlink   = r_t;
                    n_state   = S_AWRITE;
                end else if (r_step == STEP_LAST) begin
                    n_state = S_ADONE;
                end else begin
                    n_t     = r_t + 12'd1;
                    w_raddr = r_t + 12'd1;
                    n_step  = r_step + 12'd1;
                end
            end
            S_AWRITE: begin
                w_we_ent  = 1'b1;
                w_we_link = 1'b1;
                w_waddr   = r_t;
                w_wused   = 1'b1;
                w_wpfx    = r_hpfx;
                w_wsfx    = r_hsym;
                n_state   = S_ADONE;
            end
            S_ADONE: begin
                if (r_op == OP_RINS && r_root != LAST_ROOT) begin
                    n_root  = r_root + 8'd1;
                    n_state = S_RSTART;
                end else if (r_op == OP_RINS && r_init) begin
                    n_left  = GROWTH_LIMIT;
                    n_init  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    if (r_op == OP_RINS) n_left = GROWTH_LIMIT;
                    n_op    = OP_RFIND;
                    n_hpfx  = NO_PREFIX;
                    n_hsym  = r_sym;
                    n_state = S_H1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_clr   <= '0;
            r_cur   <= '0;
            r_held  <= 4'd0;
            r_pend  <= 1'b0;
            r_half  <= 1'b0;
            r_left  <= GROWTH_LIMIT;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_clr   <= n_clr;
            r_cur   <= n_cur;
            r_held  <= n_held;
            r_pend  <= n_pend;
            r_half  <= n_half;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_root  <= n_root;
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_hpfx  <= n_hpfx;
        r_hsym  <= n_hsym;
        r_hv    <= n_hv;
        r_idx   <= n_idx;
        r_t     <= n_t;
        r_step  <= n_step;
        r_ecode <= n_ecode;
        r_emiss <= n_emiss;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_ent) begin
            mem_used[w_waddr] <= w_wused;
            mem_pfx[w_waddr]  <= w_wpfx;
            mem_sfx[w_waddr]  <= w_wsfx;
        end
        if (w_we_link) mem_link[w_waddr] <= w_wlink;
        r_rd_used <= mem_used[w_raddr];
        r_rd_link <= mem_link[w_raddr];
        r_rd_pfx  <= mem_pfx[w_raddr];
        r_rd_sfx  <= mem_sfx[w_raddr];
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_out_full)
        else $error("byte pushed into a full output queue");

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_cmd_pop)
        else $error("command taken while the table is being built");

    a_flush_clears_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && !i_out_full) |=> !r_pend)
        else $error("nibble still held after flush byte");

endmodule
